// ===== rtl/core/pfc_pkg.sv =====
// Shared constants and types for the frame check and error-rate block.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package pfc_pkg;

    localparam logic [7:0]  CRC_POLY          = 8'h07;
    localparam logic [13:0] RATE_SCALE        = 14'd10000;
    localparam logic [15:0] TOTAL_LIMIT       = 16'd64000;
    localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
    localparam logic [5:0]  FRAME_BYTES_RESET = 6'd18;

    localparam int DIVISOR_W  = 16;
    localparam int DIVIDEND_W = 30;
    localparam int DIV_CNT_W  = 5;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_stat_t;

endpackage

// ===== rtl/core/pec_frame_checker_with_error_rate.sv =====
// Top level: frame sequencer, byte counters, output register.
// Depends on pfc_pkg, pfc_crc_unit and pfc_divider.
//
//  channel  direction  tdata / data                         tuser
//  s_*      in         [7:0] data_byte                      [0] ends_read
//  m_*      out        [0] pec_ok [8:1] crc_value           none
//                      [9] rate_updated [23:10] error_rate
//  cfg_*    in         [5:0] frame_bytes (cfg_we strobe)    -
//
// A data byte is taken on the accepting beat and then folded into the CRC in four
// steps of two bits. A check byte goes from the accepting beat to the emit state;
// one that ends a read sweep also passes the multiply, launch and serial divide
// states, or skips the divider when the total is still zero.
// rst_n clears all counters, the CRC and the state; frame_bytes returns to 18.
// A result held in the output register does not block input; only a new result
// waits in the emit state until the previous beat has been taken.
`timescale 1ns / 1ps

module pec_frame_checker_with_error_rate (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] ends_read
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] pec_ok, [8:1] crc_value, [9] rate_updated,
                                   // [23:10] error_rate
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CRC   = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DIVGO = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    localparam int DW = pfc_pkg::DIVIDEND_W;

    logic [2:0]    state_reg, state_next;
    logic [5:0]    fb_reg, fb_next;
    logic [7:0]    crc_acc_reg, crc_acc_next;
    logic [5:0]    pos_reg, pos_next;
    logic [15:0]   total_reg, total_next;
    logic [15:0]   bad_reg, bad_next;
    logic [13:0]   rate_reg, rate_next;
    logic [DW-1:0] prod_reg, prod_next;
    logic          ok_reg, ok_next;
    logic [7:0]    crc_val_reg, crc_val_next;
    logic          upd_reg, upd_next;
    logic          mvalid_reg, mvalid_next;
    logic [23:0]   mdata_reg, mdata_next;

    logic          accept;
    logic          pec_match;
    logic [16:0]   total_sum;
    logic [16:0]   bad_sum;
    logic [15:0]   total_sat;
    logic [15:0]   bad_sat;
    logic          crc_start;
    logic          crc_done;
    logic [7:0]    crc_result;
    logic [DW-1:0] quo_clamped;

    pfc_pkg::div_req_t  div_req;
    pfc_pkg::div_stat_t div_stat;

    pfc_crc_unit u_crc (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (crc_start),
        .byte_in (s_tdata),
        .crc_in  (crc_acc_reg),
        .done    (crc_done),
        .crc_out (crc_result)
    );

    pfc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign crc_start = accept && (pos_reg < fb_reg);
    assign pec_match = (s_tdata == crc_acc_reg);

    // Both counters saturate rather than wrap.
    assign total_sum = {1'b0, total_reg} + {11'd0, fb_reg};
    assign bad_sum   = {1'b0, bad_reg} + {11'd0, fb_reg};
    assign total_sat = total_sum[16] ? pfc_pkg::COUNT_MAX : total_sum[15:0];
    assign bad_sat   = bad_sum[16] ? pfc_pkg::COUNT_MAX : bad_sum[15:0];

    assign div_req.start    = (state_reg == ST_DIVGO);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = total_reg;

    assign quo_clamped = (div_stat.quotient > DW'(pfc_pkg::RATE_SCALE))
                         ? DW'(pfc_pkg::RATE_SCALE) : div_stat.quotient;

    always_comb
    begin
        state_next   = state_reg;
        fb_next      = cfg_we ? cfg_data : fb_reg;
        crc_acc_next = crc_acc_reg;
        pos_next     = pos_reg;
        total_next   = total_reg;
        bad_next     = bad_reg;
        rate_next    = rate_reg;
        prod_next    = prod_reg;
        ok_next      = ok_reg;
        crc_val_next = crc_val_reg;
        upd_next     = upd_reg;
        mvalid_next  = (mvalid_reg && m_tready) ? 1'b0 : mvalid_reg;
        mdata_next   = mdata_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (pos_reg < fb_reg)
                    begin
                        pos_next   = pos_reg + 6'd1;
                        state_next = ST_CRC;
                    end
                    else
                    begin
                        ok_next      = pec_match;
                        crc_val_next = crc_acc_reg;
                        upd_next     = s_tuser;
                        total_next   = total_sat;
                        if (!pec_match)
                        begin
                            bad_next = bad_sat;
                        end
                        crc_acc_next = 8'd0;
                        pos_next     = 6'd0;
                        state_next   = s_tuser ? ST_MUL : ST_EMIT;
                    end
                end
            end
            ST_CRC:
            begin
                if (crc_done)
                begin
                    crc_acc_next = crc_result;
                    state_next   = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                prod_next = DW'(bad_reg) * DW'(pfc_pkg::RATE_SCALE);
                if (total_reg == 16'd0)
                begin
                    rate_next  = 14'd0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DIVGO;
                end
            end
            ST_DIVGO:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    rate_next = quo_clamped[13:0];
                    if (total_reg > pfc_pkg::TOTAL_LIMIT)
                    begin
                        total_next = 16'd1;
                        bad_next   = 16'd0;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {rate_reg, upd_reg, crc_val_reg, ok_reg};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fb_reg      <= pfc_pkg::FRAME_BYTES_RESET;
            crc_acc_reg <= 8'd0;
            pos_reg     <= 6'd0;
            total_reg   <= 16'd0;
            bad_reg     <= 16'd0;
            rate_reg    <= 14'd0;
            upd_reg     <= 1'b0;
            mvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fb_reg      <= fb_next;
            crc_acc_reg <= crc_acc_next;
            pos_reg     <= pos_next;
            total_reg   <= total_next;
            bad_reg     <= bad_next;
            rate_reg    <= rate_next;
            upd_reg     <= upd_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        ok_reg      <= ok_next;
        crc_val_reg <= crc_val_next;
        mdata_reg   <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    // The bad count can never run ahead of the total.
    a_bad_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        bad_reg <= total_reg)
        else $error("bad byte count exceeds total byte count");

    // A delivered rate never exceeds the scale.
    a_rate_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:10] <= pfc_pkg::RATE_SCALE))
        else $error("error rate above scale");

    // Every accepted beat keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // The divider only completes while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

endmodule

// ===== rtl/core/pfc_crc_unit.sv =====
// Iterative CRC-8 unit: folds one byte into the CRC two bits per cycle.
// Depends on pfc_pkg for the polynomial.
`timescale 1ns / 1ps

module pfc_crc_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] byte_in,
    input  logic [7:0] crc_in,
    output logic       done,
    output logic [7:0] crc_out
);

    logic       busy_reg, busy_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [7:0] work_reg, work_next;
    logic [7:0] half;
    logic [7:0] step;

    // Two shift-and-reduce steps of the polynomial division.
    always_comb
    begin
        half = work_reg[7] ? ({work_reg[6:0], 1'b0} ^ pfc_pkg::CRC_POLY)
                           : {work_reg[6:0], 1'b0};
        step = half[7] ? ({half[6:0], 1'b0} ^ pfc_pkg::CRC_POLY)
                       : {half[6:0], 1'b0};
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
            work_next = crc_in ^ byte_in;
        end
        else if (busy_reg)
        begin
            work_next = step;
            cnt_next  = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
            work_reg <= 8'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            work_reg <= work_next;
        end
    end

    assign done    = busy_reg && (cnt_reg == 2'd3);
    assign crc_out = step;

endmodule

// ===== rtl/core/pfc_divider.sv =====
// Restoring serial divider: one quotient bit per cycle.
// Depends on pfc_pkg for widths and the request and status structs.
`timescale 1ns / 1ps

module pfc_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  pfc_pkg::div_req_t  req,
    output pfc_pkg::div_stat_t stat
);

    localparam int DW = pfc_pkg::DIVIDEND_W;
    localparam int VW = pfc_pkg::DIVISOR_W;
    localparam int CW = pfc_pkg::DIV_CNT_W;
    localparam logic [CW-1:0] LAST = CW'(DW - 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;

    // The dividend shifts out of the top of quo_reg as quotient bits enter below.
    always_comb
    begin
        trial = {rem_reg, quo_reg[DW-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = req.divisor;
            quo_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[VW-1:0] : trial[VW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            quo_reg  <= quo_next;
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = busy_reg && (cnt_reg == LAST);
    assign stat.quotient = {quo_reg[DW-2:0], fits};

endmodule
